// ----- sv/udp_can_frame_unpack_fifo_unit_macros.svh -----
// Assertion macros shared by the CAN frame unpack queue RTL.
// Used by files that carry concurrent checks; needs signals named clock and reset.
`ifndef UDP_CAN_FRAME_UNPACK_FIFO_UNIT_MACROS_SVH
`define UDP_CAN_FRAME_UNPACK_FIFO_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge outside reset.
`define UCFU_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("ucfu assertion failed");

// Condition that must never be true outside reset.
`define UCFU_NEVER(lbl, expr) \
   `UCFU_ASSERT(lbl, !(expr))

`else

`define UCFU_ASSERT(lbl, prop)
`define UCFU_NEVER(lbl, expr)

`endif

`endif

// ----- sv/ucfu_pkg.sv -----
// Package for the CAN frame unpack queue: codes, constants, record types and helpers.
// Used by every module of the block except ucfu_ram; depends on nothing.
`default_nettype none

package ucfu_pkg;

   // Queue geometry.
   localparam int QUEUE_DEPTH = 16;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Datagram layout.
   localparam logic [3:0] HEADER_LEN   = 4'd5;
   localparam logic [3:0] PAYLOAD_END  = 4'd13;
   localparam logic [3:0] POS_MAX      = 4'd15;
   localparam logic [3:0] MAX_DATA_LEN = 4'd8;

   // Item operation.
   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_STORED     = 3'd0,
      ST_DROP_FULL  = 3'd1,
      ST_DROP_SHORT = 3'd2,
      ST_POPPED     = 3'd3,
      ST_EMPTY      = 3'd4
   } status_type;

   // One queued CAN message.
   typedef struct packed {
      logic [1:0]  frame_type;
      logic [28:0] can_id;
      logic [3:0]  data_length;
      logic [63:0] payload;
   } ring_entry_type;

   localparam int ENTRY_W = $bits(ring_entry_type);

   // Message assembled by the unpacker on the last byte of a datagram.
   typedef struct packed {
      logic           short_frame;
      ring_entry_type entry;
   } unpack_out_type;

   // Contents of the stage between the queue control and the result register.
   typedef struct packed {
      logic       valid;
      status_type status;
   } stage_type;

   // Ring pointer advance with wrap at the queue depth.
   function automatic logic [QUEUE_AW-1:0] next_index(input logic [QUEUE_AW-1:0] ptr);
      logic [QUEUE_AW-1:0] nxt;
      if (ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + 1'b1;
      end
      return nxt;
   endfunction

   // Keeps the payload bytes below the data length and clears the rest.
   function automatic logic [63:0] payload_mask(input logic [3:0] len);
      logic [63:0] mask;
      mask = '0;
      for (int i = 0; i < 8; i++) begin
         mask[8*i +: 8] = (4'(i) < len) ? 8'hFF : 8'h00;
      end
      return mask;
   endfunction

endpackage

`default_nettype wire

// ----- sv/ucfu_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the message ring of the CAN frame unpack queue.
`default_nettype none

module ucfu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- sv/ucfu_unpack.sv -----
// Datagram byte staging and header unpacking into a CAN message record.
// Depends on ucfu_pkg.
`default_nettype none

module ucfu_unpack (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     byte_en,
   input  wire logic [7:0]               data_byte,
   input  wire logic                     last_byte,
   output ucfu_pkg::unpack_out_type      frame
);

   logic [3:0]  pos_ff;
   logic [3:0]  pos_in;
   logic [39:0] header_ff;
   logic [39:0] header_in;
   logic [63:0] payload_ff;
   logic [63:0] payload_in;
   logic [2:0]  pay_idx;
   logic [7:0]  b0, b1, b2, b3, b4;
   logic [6:0]  raw_len;
   logic [3:0]  data_len;
   logic        ext_flag;

   // Place the incoming byte into the header or the payload staging.
   always_comb begin
      header_in  = header_ff;
      payload_in = payload_ff;
      pay_idx    = 3'(pos_ff - ucfu_pkg::HEADER_LEN);
      if (pos_ff < ucfu_pkg::HEADER_LEN) begin
         header_in[{pos_ff[2:0], 3'b000} +: 8] = data_byte;
      end else if (pos_ff < ucfu_pkg::PAYLOAD_END) begin
         payload_in[{pay_idx, 3'b000} +: 8] = data_byte;
      end
      pos_in = (pos_ff == ucfu_pkg::POS_MAX) ? pos_ff : pos_ff + 4'd1;
   end

   // Unpack the header as it stands once the current byte is included.
   always_comb begin
      b0       = header_in[7:0];
      b1       = header_in[15:8];
      b2       = header_in[23:16];
      b3       = header_in[31:24];
      b4       = header_in[39:32];
      ext_flag = b1[3];
      raw_len  = b4[7:1];
      data_len = (raw_len > 7'(ucfu_pkg::MAX_DATA_LEN)) ? ucfu_pkg::MAX_DATA_LEN
                                                        : raw_len[3:0];
      frame.short_frame       = (pos_in < ucfu_pkg::HEADER_LEN);
      frame.entry.frame_type  = {ext_flag, b4[0]};
      frame.entry.data_length = data_len;
      frame.entry.payload     = payload_in & ucfu_pkg::payload_mask(data_len);
      if (ext_flag) begin
         frame.entry.can_id = {b0, b1[7:5], b1[1:0], b2, b3};
      end else begin
         frame.entry.can_id = {13'd0, b2, b3};
      end
   end

   // Staging registers; the last byte clears them for the next datagram.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         header_ff  <= '0;
         payload_ff <= '0;
      end else if (byte_en) begin
         if (last_byte) begin
            pos_ff     <= '0;
            header_ff  <= '0;
            payload_ff <= '0;
         end else begin
            pos_ff     <= pos_in;
            header_ff  <= header_in;
            payload_ff <= payload_in;
         end
      end
   end

endmodule

`default_nettype wire

// ----- sv/ucfu_queue_ctrl.sv -----
// Ring pointer control and status decision for the CAN message queue.
// Depends on ucfu_pkg and the assertion macro header.
`default_nettype none
`include "udp_can_frame_unpack_fifo_unit_macros.svh"

module ucfu_queue_ctrl (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              advance,
   input  wire logic                              push,
   input  wire logic                              pop,
   input  wire ucfu_pkg::unpack_out_type          frame,
   output ucfu_pkg::stage_type                    stage,
   output logic                                   ram_wr_en,
   output logic [ucfu_pkg::QUEUE_AW-1:0]          ram_wr_addr,
   output ucfu_pkg::ring_entry_type               ram_wr_data,
   output logic                                   ram_rd_en,
   output logic [ucfu_pkg::QUEUE_AW-1:0]          ram_rd_addr
);

   logic [ucfu_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ucfu_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic                          last_read_ff, last_read_in;
   ucfu_pkg::stage_type           stage_ff, stage_in;
   logic                          same_ptr;
   logic                          q_empty;
   logic                          q_full;

   assign same_ptr = (wr_ptr_ff == rd_ptr_ff);
   assign q_empty  = same_ptr && last_read_ff;
   assign q_full   = same_ptr && !last_read_ff;

   // Decide the status of the transaction and move the pointers.
   always_comb begin
      wr_ptr_in       = wr_ptr_ff;
      rd_ptr_in       = rd_ptr_ff;
      last_read_in    = last_read_ff;
      stage_in.valid  = 1'b0;
      stage_in.status = ucfu_pkg::ST_STORED;
      ram_wr_en       = 1'b0;
      ram_rd_en       = 1'b0;
      if (pop) begin
         stage_in.valid = 1'b1;
         if (q_empty) begin
            stage_in.status = ucfu_pkg::ST_EMPTY;
         end else begin
            stage_in.status = ucfu_pkg::ST_POPPED;
            ram_rd_en       = 1'b1;
            rd_ptr_in       = ucfu_pkg::next_index(rd_ptr_ff);
            last_read_in    = 1'b1;
         end
      end else if (push) begin
         stage_in.valid = 1'b1;
         if (q_full) begin
            stage_in.status = ucfu_pkg::ST_DROP_FULL;
         end else if (frame.short_frame) begin
            stage_in.status = ucfu_pkg::ST_DROP_SHORT;
         end else begin
            stage_in.status = ucfu_pkg::ST_STORED;
            ram_wr_en       = 1'b1;
            wr_ptr_in       = ucfu_pkg::next_index(wr_ptr_ff);
            last_read_in    = 1'b0;
         end
      end
   end

   assign ram_wr_addr = wr_ptr_ff;
   assign ram_wr_data = frame.entry;
   assign ram_rd_addr = rd_ptr_ff;

   // Pointer and flag registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         last_read_ff <= 1'b1;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         last_read_ff <= last_read_in;
      end
   end

   // Stage register, level with the RAM read data; it holds while the output stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid  <= 1'b0;
         stage_ff.status <= ucfu_pkg::ST_STORED;
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign stage = stage_ff;

   // A transaction is either a store or a pop, never both at once.
   `UCFU_NEVER(a_no_wr_rd_same_cycle, ram_wr_en && ram_rd_en)
   // A store leaves the queue non-empty.
   `UCFU_ASSERT(a_store_not_empty, ram_wr_en |=> !q_empty)
   // A pop leaves the queue non-full.
   `UCFU_ASSERT(a_pop_not_full, ram_rd_en |=> !q_full)
   // Nothing is decided while the stage is held.
   `UCFU_NEVER(a_no_work_when_held, !advance && (push || pop))

endmodule

`default_nettype wire

// ----- sv/udp_can_frame_unpack_fifo_unit.sv -----
// Top level of the CAN frame unpack queue: handshake, ring RAM and result register.
// Depends on ucfu_pkg, ucfu_unpack, ucfu_queue_ctrl, ucfu_ram and the macro header.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall  op, data_byte, last_byte
//   rsp_      out        rsp_valid/rsp_stall  status, frame_type, can_id, data_length,
//                                             payload, total_length
//
// One transaction is accepted per cycle while req_stall is low; its result is registered first in the
// stage register, level with the ring RAM's registered read, and then in the result register.
// A datagram byte that is not the last gives no result.
// Reset clears the staging, pointers and pipeline valids; ring contents need no clearing.
// A stalled result holds the whole pipeline: req_stall is high while rsp_valid and rsp_stall are.
`default_nettype none
`include "udp_can_frame_unpack_fifo_unit_macros.svh"

module udp_can_frame_unpack_fifo_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_op,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [1:0]       rsp_frame_type,
   output logic [28:0]      rsp_can_id,
   output logic [3:0]       rsp_data_length,
   output logic [63:0]      rsp_payload,
   output logic [3:0]       rsp_total_length
);

   logic                          advance;
   logic                          accept;
   logic                          byte_en;
   logic                          push;
   logic                          pop;
   ucfu_pkg::unpack_out_type      frame;
   ucfu_pkg::stage_type           stage;
   logic                          ram_wr_en;
   logic [ucfu_pkg::QUEUE_AW-1:0] ram_wr_addr;
   ucfu_pkg::ring_entry_type      ram_wr_data;
   logic                          ram_rd_en;
   logic [ucfu_pkg::QUEUE_AW-1:0] ram_rd_addr;
   ucfu_pkg::ring_entry_type      ram_rd_data;
   logic                          rsp_valid_ff;
   ucfu_pkg::status_type          rsp_status_ff;
   ucfu_pkg::ring_entry_type      rsp_entry_ff;
   ucfu_pkg::ring_entry_type      rsp_entry_in;

   // The pipeline moves whenever the result register is free or being emptied.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;
   assign byte_en   = accept && (ucfu_pkg::op_type'(req_op) == ucfu_pkg::OP_BYTE);
   assign pop       = accept && (ucfu_pkg::op_type'(req_op) == ucfu_pkg::OP_POP);
   assign push      = byte_en && req_last_byte;

   ucfu_unpack u_unpack (
      .clock     (clock),
      .reset     (reset),
      .byte_en   (byte_en),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .frame     (frame)
   );

   ucfu_queue_ctrl u_queue_ctrl (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .push        (push),
      .pop         (pop),
      .frame       (frame),
      .stage       (stage),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr)
   );

   ucfu_ram #(
      .WIDTH (ucfu_pkg::ENTRY_W),
      .DEPTH (ucfu_pkg::QUEUE_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Message fields are shown only for a pop; every other status carries zeros.
   always_comb begin
      if (stage.status == ucfu_pkg::ST_POPPED) begin
         rsp_entry_in = ram_rd_data;
      end else begin
         rsp_entry_in = '0;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= stage.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_status_ff <= stage.status;
         rsp_entry_ff  <= rsp_entry_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_frame_type   = rsp_entry_ff.frame_type;
   assign rsp_can_id       = rsp_entry_ff.can_id;
   assign rsp_data_length  = rsp_entry_ff.data_length;
   assign rsp_payload      = rsp_entry_ff.payload;
   assign rsp_total_length = (rsp_status_ff == ucfu_pkg::ST_POPPED)
                             ? 4'(rsp_entry_ff.data_length + ucfu_pkg::HEADER_LEN)
                             : 4'd0;

   // Only a popped message carries an identifier or payload.
   `UCFU_ASSERT(a_fields_zero_unless_pop,
      (rsp_valid_ff && (rsp_status_ff != ucfu_pkg::ST_POPPED))
         |-> ((rsp_can_id == 29'd0) && (rsp_payload == 64'd0)))
   // A popped message never reports more than eight data bytes.
   `UCFU_NEVER(a_len_saturated,
      rsp_valid_ff && (rsp_status_ff == ucfu_pkg::ST_POPPED)
         && (rsp_data_length > ucfu_pkg::MAX_DATA_LEN))

endmodule

`default_nettype wire
